@@ rtl/dirty_rect_pixel_tracker_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the dirty rectangle tracker
// Clocked, reset-qualified implication checks used by the tracker module.
// ---------------------------------------------------------------------------
`ifndef DIRTY_RECT_PIXEL_TRACKER_ASSERT_SVH
`define DIRTY_RECT_PIXEL_TRACKER_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define DRPT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define DRPT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/drpt_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// drpt_pkg
// Panel geometry, field widths and types of the dirty rectangle tracker.
// ---------------------------------------------------------------------------
package drpt_pkg;

	localparam int PANEL_WIDTH  = 480;
	localparam int PANEL_HEIGHT = 272;
	localparam int DEPTH        = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int ADDR_W       = $clog2(DEPTH);

	localparam int COORD_W = 9;
	localparam int CHAN_W  = 8;
	localparam int PIX_W   = 16;

	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 40;
	localparam int RECT_W   = 4 * COORD_W;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [PIX_W-1:0]   pix_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	// Left in the lowest bits, as on the output bus.
	typedef struct packed {
		coord_t bottom;
		coord_t right;
		coord_t top;
		coord_t left;
	} rect_t;

	// RGB565 with the two bytes swapped.
	function automatic pix_t pack_swapped(input logic [CHAN_W-1:0] r,
		input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		pix_t p;
		p = {r[7:3], g[7:2], b[7:3]};
		return {p[7:0], p[15:8]};
	endfunction

endpackage
`default_nettype wire

@@ rtl/dirty_rect_pixel_tracker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dirty_rect_pixel_tracker
// Compares each pixel with a shadow framebuffer and reports the dirty box.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Word contents                         Marker
//  -------  ---------  ------------------------------------  -------------------
//  s_*      in         col, row, red, green, blue            tlast = area end
//  m_*      out        rect_left, rect_top, rect_right, bot  none
//
// One pixel word is taken every cycle while s_tready is high. The shadow store is a single-port-write
// RAM with a registered read: the read is issued as the word is accepted and
// the compare and write-back happen in the next cycle, with the previous write
// forwarded when two pixels in a row hit the same entry.
// After reset all PANEL_WIDTH * PANEL_HEIGHT entries (130560) of the store are swept
// to zero, one entry per cycle; no pixel is taken during the sweep.
// Results go to a two-word output queue; after the sweep, input stalls only when
// that queue could fill up behind a stalled output side.
//
`include "dirty_rect_pixel_tracker_assert.svh"

module dirty_rect_pixel_tracker (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0 up: pixel_col[8:0], pixel_row[17:9], red[25:18],
	// green[33:26], blue[41:34], zero padding[47:42].
	input  wire  [drpt_pkg::S_DATA_W-1:0]  s_tdata,
	input  wire                            s_tlast,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// Fields from bit 0 up: rect_left[8:0], rect_top[17:9], rect_right[26:18],
	// rect_bottom[35:27], zero padding[39:36].
	output logic [drpt_pkg::M_DATA_W-1:0]  m_tdata
);
	import drpt_pkg::*;

	// Input unpacking.
	coord_t in_col;
	coord_t in_row;
	logic   in_panel;
	addr_t  in_addr;
	pix_t   in_pix;
	logic   accept;

	assign in_col   = s_tdata[8:0];
	assign in_row   = s_tdata[17:9];
	assign in_pix   = pack_swapped(s_tdata[25:18], s_tdata[33:26], s_tdata[41:34]);
	assign in_panel = (32'(in_col) < 32'(PANEL_WIDTH)) && (32'(in_row) < 32'(PANEL_HEIGHT));
	assign in_addr  = ADDR_W'(in_row) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(in_col);
	assign accept   = s_tvalid && s_tready;

	// Store clearing sweep after reset.
	logic  clearing_q;
	addr_t clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Compare stage.
	logic   valid_s1;
	logic   in_panel_s1;
	logic   last_s1;
	addr_t  addr_s1;
	pix_t   pix_s1;
	coord_t col_s1;
	coord_t row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_panel_s1 <= in_panel;
			last_s1     <= s_tlast;
			addr_s1     <= in_addr;
			pix_s1      <= in_pix;
			col_s1      <= in_col;
			row_s1      <= in_row;
		end
	end

	// Shadow framebuffer.
	pix_t  shadow_mem [DEPTH];
	pix_t  mem_rdata_s1;
	logic  mem_we;
	addr_t mem_waddr;
	pix_t  mem_wdata;
	logic  s1_write;

	assign mem_we    = clearing_q || s1_write;
	assign mem_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign mem_wdata = clearing_q ? '0 : pix_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			shadow_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_s1 <= shadow_mem[in_addr];
	end

	// The read issued alongside a write-back sees the old entry, so the last
	// write is held in a register and wins on an address match.
	logic  fwd_valid_q;
	addr_t fwd_addr_q;
	pix_t  fwd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= s1_write;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_write) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= pix_s1;
		end
	end

	pix_t old_pix;
	assign old_pix  = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : mem_rdata_s1;
	assign s1_write = valid_s1 && in_panel_s1 && (old_pix != pix_s1);

	// Dirty box.
	coord_t box_left_q;
	coord_t box_top_q;
	coord_t box_right_q;
	coord_t box_bottom_q;
	logic   any_change_q;
	coord_t nxt_left;
	coord_t nxt_top;
	coord_t nxt_right;
	coord_t nxt_bottom;
	logic   nxt_any;
	logic   s1_end;
	logic   push;

	always_comb begin
		nxt_left   = box_left_q;
		nxt_top    = box_top_q;
		nxt_right  = box_right_q;
		nxt_bottom = box_bottom_q;
		nxt_any    = any_change_q;
		if (s1_write) begin
			if (col_s1 < box_left_q)   nxt_left   = col_s1;
			if (row_s1 < box_top_q)    nxt_top    = row_s1;
			if (col_s1 > box_right_q)  nxt_right  = col_s1;
			if (row_s1 > box_bottom_q) nxt_bottom = row_s1;
			nxt_any = 1'b1;
		end
	end

	assign s1_end = valid_s1 && last_s1;
	assign push   = s1_end && nxt_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= COORD_W'(PANEL_WIDTH);
			box_top_q    <= COORD_W'(PANEL_HEIGHT);
			box_right_q  <= '0;
			box_bottom_q <= '0;
			any_change_q <= 1'b0;
		end else if (s1_end) begin
			box_left_q   <= COORD_W'(PANEL_WIDTH);
			box_top_q    <= COORD_W'(PANEL_HEIGHT);
			box_right_q  <= '0;
			box_bottom_q <= '0;
			any_change_q <= 1'b0;
		end else begin
			box_left_q   <= nxt_left;
			box_top_q    <= nxt_top;
			box_right_q  <= nxt_right;
			box_bottom_q <= nxt_bottom;
			any_change_q <= nxt_any;
		end
	end

	// Block alignment, with the far edges held inside the panel.
	rect_t  rect_new;
	coord_t right_up;
	coord_t bottom_up;

	assign right_up  = nxt_right | COORD_W'(7);
	assign bottom_up = nxt_bottom | COORD_W'(3);

	always_comb begin
		rect_new.left   = nxt_left & ~COORD_W'(7);
		rect_new.top    = nxt_top & ~COORD_W'(3);
		rect_new.right  = right_up;
		rect_new.bottom = bottom_up;
		if (32'(right_up) > PANEL_WIDTH - 1)   rect_new.right  = COORD_W'(PANEL_WIDTH - 1);
		if (32'(bottom_up) > PANEL_HEIGHT - 1) rect_new.bottom = COORD_W'(PANEL_HEIGHT - 1);
	end

	// Two-word result queue.
	rect_t      res_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {(M_DATA_W - RECT_W)'(0), res_q[rd_ptr_q]};

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wr_ptr_q] <= rect_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// A word in the compare stage that may still produce a result holds a
	// queue slot in reserve, so the compare stage never has to stall. A word
	// leaving the queue in this cycle frees its slot for the incoming pixel.
	assign s_tready = !clearing_q &&
		((cnt_q == 2'd0) ||
		((cnt_q == 2'd1) && (!s1_end || m_tready)) ||
		((cnt_q == 2'd2) && m_tready));

	`DRPT_ASSERT_IMP(a_queue_no_overflow, push && !pop, cnt_q != 2'd2, "result queue overflow")
	`DRPT_ASSERT_IMP(a_no_write_in_sweep, clearing_q, !s1_write, "pixel write during clear sweep")
	`DRPT_ASSERT_NXT(a_sweep_done_on_accept, accept, !clearing_q && valid_s1, "accept during sweep")
	`DRPT_ASSERT_IMP(a_rect_ordered, m_tvalid, (res_q[rd_ptr_q].left <= res_q[rd_ptr_q].right) && (res_q[rd_ptr_q].top <= res_q[rd_ptr_q].bottom), "inverted result box")

endmodule
`default_nettype wire
